@@ design/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Request and result payloads, operation codes and controller states.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
    localparam int MAG_WIDTH     = 64;
    localparam int DEN_WIDTH     = 62;
    localparam int CNT_WIDTH     = $clog2(MAG_WIDTH);
    localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH) + 1;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_COMBINE,
        S_PREP,
        S_GCD,
        S_SCALE,
        S_DIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        kind_t                             kind;
        logic signed [OPERAND_WIDTH-1:0]   first_numerator;
        logic        [OPERAND_WIDTH-2:0]   first_denominator;
        logic signed [OPERAND_WIDTH-1:0]   second_numerator;
        logic        [OPERAND_WIDTH-2:0]   second_denominator;
    } operand_t;

    typedef struct packed {
        logic signed [MAG_WIDTH-1:0] result_numerator;
        logic        [DEN_WIDTH-1:0] result_denominator;
        logic                        error;
    } result_t;

endpackage

@@ design/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add, subtract, multiply and divide
// Cross-multiplies two signed fractions and reduces the result to lowest
// terms through a binary GCD and a bit-serial division by it.
// ----------------------------------------------------------------------------
//
//  channel   signals                              payload
//  -------   ----------------------------------   ----------------------------
//  request   operand_valid / operand_ready        operand (rau_pkg::operand_t)
//  result    result_valid / result_ready          result  (rau_pkg::result_t)
//
//  One request at a time. Multiply is shift-add, one multiplier bit per cycle;
//  the binary GCD then runs one step per cycle, scaling restores the common
//  power of two, and the two parallel restoring divisions give both quotients.
//  Error requests go straight from idle to the finish state, and a zero
//  numerator skips the GCD and divisions.
//  Reset returns the controller to idle and drops any pending result.
//  A new request is taken while a finished result still waits on result_ready.
module rational_arithmetic_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              operand_valid,
    output logic              operand_ready,
    input  rau_pkg::operand_t operand,
    output logic              result_valid,
    input  logic              result_ready,
    output rau_pkg::result_t  result
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    kind_t                    kind_reg, kind_next;
    logic                     s1_reg, s1_next;
    logic                     s2_reg, s2_next;
    logic [OPERAND_WIDTH-1:0] ma_reg, ma_next, mb_reg, mb_next, mc_reg, mc_next;
    logic [OPERAND_WIDTH-1:0] ya_reg, ya_next, yb_reg, yb_next, yc_reg, yc_next;
    logic [PROD_WIDTH-1:0]    pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next;
    logic [CNT_WIDTH-1:0]     cnt_reg, cnt_next;
    logic signed [MAG_WIDTH-1:0] num_reg, num_next;
    logic                     neg_reg, neg_next;
    logic                     zero_reg, zero_next;
    logic                     err_reg, err_next;
    logic [MAG_WIDTH-1:0]     nmag_reg, nmag_next, dmag_reg, dmag_next;
    logic [MAG_WIDTH-1:0]     x_reg, x_next, y_reg, y_next;
    logic [SHIFT_WIDTH-1:0]   k_reg, k_next;
    logic [MAG_WIDTH-1:0]     rem_n_reg, rem_n_next, rem_d_reg, rem_d_next;
    logic                     rv_reg, rv_next;
    result_t                  out_reg, out_next;

    logic                     load_out;
    logic                     in_err;
    logic [OPERAND_WIDTH-1:0] n1_mag, n2_mag, d1_ext, d2_ext;
    logic [OPERAND_WIDTH:0]   sum_a, sum_b, sum_c;
    logic signed [MAG_WIDTH-1:0] t1, t2;
    logic [MAG_WIDTH:0]       sh_n, sh_d;
    logic                     ge_n, ge_d;

    // Operand magnitudes and request error check
    always_comb
    begin
        n1_mag = operand.first_numerator[OPERAND_WIDTH-1]
               ? OPERAND_WIDTH'(~operand.first_numerator + 1'b1)
               : OPERAND_WIDTH'(operand.first_numerator);
        n2_mag = operand.second_numerator[OPERAND_WIDTH-1]
               ? OPERAND_WIDTH'(~operand.second_numerator + 1'b1)
               : OPERAND_WIDTH'(operand.second_numerator);
        d1_ext = {1'b0, operand.first_denominator};
        d2_ext = {1'b0, operand.second_denominator};
        in_err = (operand.first_denominator == '0) || (operand.second_denominator == '0)
              || ((operand.kind == KIND_DIV) && (operand.second_numerator == '0));
    end

    // Shift-add steps, signed combine, and division steps
    always_comb
    begin
        sum_a = {1'b0, pa_reg[PROD_WIDTH-1:OPERAND_WIDTH]} + (ya_reg[0] ? {1'b0, ma_reg} : '0);
        sum_b = {1'b0, pb_reg[PROD_WIDTH-1:OPERAND_WIDTH]} + (yb_reg[0] ? {1'b0, mb_reg} : '0);
        sum_c = {1'b0, pc_reg[PROD_WIDTH-1:OPERAND_WIDTH]} + (yc_reg[0] ? {1'b0, mc_reg} : '0);

        t1 = (s1_reg ^ (((kind_reg == KIND_MUL) || (kind_reg == KIND_DIV)) & s2_reg))
           ? -$signed(MAG_WIDTH'(pa_reg)) : $signed(MAG_WIDTH'(pa_reg));
        if ((kind_reg == KIND_ADD) || (kind_reg == KIND_SUB))
        begin
            t2 = (s2_reg ^ (kind_reg == KIND_SUB))
               ? -$signed(MAG_WIDTH'(pb_reg)) : $signed(MAG_WIDTH'(pb_reg));
        end
        else
        begin
            t2 = '0;
        end

        sh_n = {rem_n_reg, nmag_reg[MAG_WIDTH-1]};
        sh_d = {rem_d_reg, dmag_reg[MAG_WIDTH-1]};
        ge_n = sh_n >= {1'b0, x_reg};
        ge_d = sh_d >= {1'b0, x_reg};
    end

    assign load_out = (state_reg == S_FINISH) && (!rv_reg || result_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (operand_valid)
                    state_next = in_err ? S_FINISH : S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg == CNT_WIDTH'(OPERAND_WIDTH - 1))
                    state_next = S_COMBINE;
            end
            S_COMBINE: state_next = S_PREP;
            S_PREP:    state_next = (num_reg == '0) ? S_FINISH : S_GCD;
            S_GCD:
            begin
                if (x_reg == y_reg)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (k_reg == '0)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_WIDTH'(MAG_WIDTH - 1))
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        kind_next  = kind_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        mc_next    = mc_reg;
        ya_next    = ya_reg;
        yb_next    = yb_reg;
        yc_next    = yc_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        err_next   = err_reg;
        nmag_next  = nmag_reg;
        dmag_next  = dmag_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        k_next     = k_reg;
        rem_n_next = rem_n_reg;
        rem_d_next = rem_d_reg;
        out_next   = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the request and set up the three multipliers
                if (operand_valid)
                begin
                    kind_next = operand.kind;
                    s1_next   = operand.first_numerator[OPERAND_WIDTH-1];
                    s2_next   = operand.second_numerator[OPERAND_WIDTH-1];
                    ma_next   = n1_mag;
                    ya_next   = (operand.kind == KIND_MUL) ? n2_mag : d2_ext;
                    mb_next   = n2_mag;
                    yb_next   = d1_ext;
                    mc_next   = d1_ext;
                    yc_next   = (operand.kind == KIND_DIV) ? n2_mag : d2_ext;
                    pa_next   = '0;
                    pb_next   = '0;
                    pc_next   = '0;
                    cnt_next  = '0;
                    zero_next = in_err;
                    err_next  = in_err;
                end
            end
            S_MUL:
            begin
                // Advance each product by one multiplier bit
                pa_next  = {sum_a, pa_reg[OPERAND_WIDTH-1:1]};
                pb_next  = {sum_b, pb_reg[OPERAND_WIDTH-1:1]};
                pc_next  = {sum_c, pc_reg[OPERAND_WIDTH-1:1]};
                ya_next  = ya_reg >> 1;
                yb_next  = yb_reg >> 1;
                yc_next  = yc_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
            end
            S_COMBINE:
            begin
                num_next = t1 + t2;
            end
            S_PREP:
            begin
                // Split into sign and magnitude; zero numerator gives 0/1
                zero_next = (num_reg == '0);
                neg_next  = num_reg[MAG_WIDTH-1];
                nmag_next = num_reg[MAG_WIDTH-1] ? MAG_WIDTH'(-num_reg) : MAG_WIDTH'(num_reg);
                dmag_next = MAG_WIDTH'(pc_reg);
                x_next    = num_reg[MAG_WIDTH-1] ? MAG_WIDTH'(-num_reg) : MAG_WIDTH'(num_reg);
                y_next    = MAG_WIDTH'(pc_reg);
                k_next    = '0;
            end
            S_GCD:
            begin
                // One binary GCD step
                if (x_reg != y_reg)
                begin
                    if (!x_reg[0] && !y_reg[0])
                    begin
                        x_next = x_reg >> 1;
                        y_next = y_reg >> 1;
                        k_next = k_reg + 1'b1;
                    end
                    else if (!x_reg[0])
                    begin
                        x_next = x_reg >> 1;
                    end
                    else if (!y_reg[0])
                    begin
                        y_next = y_reg >> 1;
                    end
                    else if (x_reg > y_reg)
                    begin
                        x_next = (x_reg - y_reg) >> 1;
                    end
                    else
                    begin
                        y_next = (y_reg - x_reg) >> 1;
                    end
                end
            end
            S_SCALE:
            begin
                // Restore the common power of two, then clear the remainders
                if (k_reg != '0)
                begin
                    x_next = x_reg << 1;
                    k_next = k_reg - 1'b1;
                end
                else
                begin
                    rem_n_next = '0;
                    rem_d_next = '0;
                    cnt_next   = '0;
                end
            end
            S_DIV:
            begin
                // One restoring division bit for both quotients
                rem_n_next = ge_n ? MAG_WIDTH'(sh_n - {1'b0, x_reg}) : sh_n[MAG_WIDTH-1:0];
                rem_d_next = ge_d ? MAG_WIDTH'(sh_d - {1'b0, x_reg}) : sh_d[MAG_WIDTH-1:0];
                nmag_next  = {nmag_reg[MAG_WIDTH-2:0], ge_n};
                dmag_next  = {dmag_reg[MAG_WIDTH-2:0], ge_d};
                cnt_next   = cnt_reg + 1'b1;
            end
            S_FINISH:
            begin
                if (load_out)
                begin
                    out_next.error = err_reg;
                    if (zero_reg)
                    begin
                        out_next.result_numerator   = '0;
                        out_next.result_denominator = DEN_WIDTH'(1);
                    end
                    else
                    begin
                        out_next.result_numerator   = neg_reg ? -$signed(nmag_reg)
                                                              : $signed(nmag_reg);
                        out_next.result_denominator = dmag_reg[DEN_WIDTH-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // Result valid flag: set on load, drop when taken
    always_comb
    begin
        if (load_out)
            rv_next = 1'b1;
        else if (result_ready)
            rv_next = 1'b0;
        else
            rv_next = rv_reg;
    end

    // Port outputs
    always_comb
    begin
        operand_ready = (state_reg == S_IDLE);
        result_valid  = rv_reg;
        result        = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        mc_reg    <= mc_next;
        ya_reg    <= ya_next;
        yb_reg    <= yb_next;
        yc_reg    <= yc_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        pc_reg    <= pc_next;
        cnt_reg   <= cnt_next;
        num_reg   <= num_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        err_reg   <= err_next;
        nmag_reg  <= nmag_next;
        dmag_reg  <= dmag_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        k_reg     <= k_next;
        rem_n_reg <= rem_n_next;
        rem_d_reg <= rem_d_next;
        out_reg   <= out_next;
    end

    // GCD operands never reach zero
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD) |-> (x_reg != '0) && (y_reg != '0))
        else $error("GCD operand is zero");

    // Division remainders stay below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_n_reg < x_reg) && (rem_d_reg < x_reg))
        else $error("division remainder out of range");

    // Delivered denominators are positive
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.result_denominator != '0))
        else $error("zero result denominator");

    // An error result carries 0/1
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.error) |->
            (result.result_numerator == '0) && (result.result_denominator == DEN_WIDTH'(1)))
        else $error("error result is not 0/1");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rational arithmetic unit
// Drives fraction requests through the valid/ready channel, predicts each
// reduced result and compares every field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
    import rau_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int RANDOM_ITEMS   = 650;
    localparam int HOLD_CYCLES    = 1500;

    logic     clk;
    logic     rst_n;
    logic     operand_valid;
    logic     operand_ready;
    operand_t operand;
    logic     result_valid;
    logic     result_ready;
    result_t  result;

    operand_t pending_q[$];
    result_t  fraction_q[$];
    int       fail_count;
    bit       stim_done;
    bit       quiet_mode;
    bit       hold_results;
    bit       hold_done;
    int       hold_cycles;
    int       send_gap;
    int       recv_gap;
    int       idle_cycles;

    rational_arithmetic_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_ready (operand_ready),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

    // Generate the clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Compute the reduced fraction for one request
    function automatic result_t reduce_fraction(operand_t req);
        result_t     res;
        logic signed [63:0] n1, n2, d1, d2, num, den;
        logic [63:0] nmag, dmag, a, b, t;
        bit          neg;
        begin
            res = '0;
            res.result_denominator = 62'd1;
            n1 = 64'(signed'(req.first_numerator));
            n2 = 64'(signed'(req.second_numerator));
            d1 = {33'd0, req.first_denominator};
            d2 = {33'd0, req.second_denominator};
            if (d1 == 0 || d2 == 0 || (req.kind == KIND_DIV && n2 == 0))
            begin
                res.error = 1'b1;
                return res;
            end
            case (req.kind)
                KIND_ADD: begin num = n1 * d2 + n2 * d1; den = d1 * d2; end
                KIND_SUB: begin num = n1 * d2 - n2 * d1; den = d1 * d2; end
                KIND_MUL: begin num = n1 * n2; den = d1 * d2; end
                default:  begin num = n1 * d2; den = d1 * n2; end
            endcase
            if (num == 0)
                return res;
            neg  = (num < 0) != (den < 0);
            nmag = (num < 0) ? -num : num;
            dmag = (den < 0) ? -den : den;
            a = nmag;
            b = dmag;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            nmag = nmag / a;
            dmag = dmag / a;
            res.result_numerator   = neg ? -nmag : nmag;
            res.result_denominator = dmag[61:0];
            return res;
        end
    endfunction

    function automatic operand_t rand_request(bit wellformed);
        operand_t req;
        begin
            req.kind = kind_t'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: begin
                    req.first_numerator  = $urandom;
                    req.second_numerator = $urandom;
                end
                1: begin
                    req.first_numerator  = 32'(int'($urandom_range(0, 40)) - 20);
                    req.second_numerator = 32'(int'($urandom_range(0, 40)) - 20);
                end
                default: begin
                    req.first_numerator  = 32'(int'($urandom_range(0, 2000)) - 1000);
                    req.second_numerator = $urandom;
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                req.first_denominator  = 31'($urandom_range(1, 60));
                req.second_denominator = 31'($urandom_range(1, 60)) * 31'(2 ** $urandom_range(0, 20));
            end
            else
            begin
                req.first_denominator  = 31'($urandom);
                req.second_denominator = 31'($urandom);
            end
            if (!wellformed)
            begin
                if ($urandom_range(0, 1))
                    req.first_denominator = '0;
                else
                    req.second_denominator = '0;
            end
            return req;
        end
    endfunction

    function automatic operand_t make_request(kind_t k, logic [31:0] n1, logic [30:0] d1,
                                              logic [31:0] n2, logic [30:0] d2);
        operand_t req;
        begin
            req.kind               = k;
            req.first_numerator    = n1;
            req.first_denominator  = d1;
            req.second_numerator   = n2;
            req.second_denominator = d2;
            return req;
        end
    endfunction

    // Fill the request queue and pace the phases
    initial
    begin
        fail_count   = 0;
        stim_done    = 0;
        quiet_mode   = 0;
        hold_results = 0;
        rst_n        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every operation, extremes, zero and error cases
        pending_q.push_back(make_request(KIND_ADD, 32'd1, 31'd2, 32'd1, 31'd3));
        pending_q.push_back(make_request(KIND_SUB, 32'd1, 31'd2, 32'd1, 31'd2));
        pending_q.push_back(make_request(KIND_MUL, -32'sd3, 31'd4, 32'd2, 31'd9));
        pending_q.push_back(make_request(KIND_DIV, 32'd5, 31'd6, -32'sd10, 31'd3));
        pending_q.push_back(make_request(KIND_DIV, 32'd5, 31'd6, 32'd0, 31'd3));
        pending_q.push_back(make_request(KIND_ADD, 32'd5, 31'd0, 32'd1, 31'd3));
        pending_q.push_back(make_request(KIND_MUL, 32'd5, 31'd7, 32'd1, 31'd0));
        pending_q.push_back(make_request(KIND_MUL, 32'd0, 31'd7, 32'd9, 31'd5));
        pending_q.push_back(make_request(KIND_ADD, 32'h8000_0000, 31'h7fff_ffff,
                                         32'h8000_0000, 31'h7fff_fffe));
        pending_q.push_back(make_request(KIND_SUB, 32'h7fff_ffff, 31'h7fff_ffff,
                                         32'h8000_0000, 31'h7fff_fffe));
        pending_q.push_back(make_request(KIND_MUL, 32'h8000_0000, 31'd1,
                                         32'h8000_0000, 31'd1));
        pending_q.push_back(make_request(KIND_DIV, 32'h8000_0000, 31'h7fff_ffff,
                                         32'h7fff_ffff, 31'h7fff_fffd));
        pending_q.push_back(make_request(KIND_DIV, 32'h7fff_ffff, 31'd1,
                                         32'h8000_0000, 31'h7fff_ffff));
        pending_q.push_back(make_request(KIND_MUL, 32'hffff_ffff, 31'h4000_0000,
                                         32'hffff_ffff, 31'h4000_0000));
        pending_q.push_back(make_request(KIND_SUB, 32'h5555_5555, 31'h2aaa_aaaa,
                                         32'haaaa_aaaa, 31'h5555_5555));

        // sender pause: wait for every result
        wait (pending_q.size() == 0 && fraction_q.size() == 0);

        // receiver holds off while requests keep coming
        hold_results = 1;
        repeat (8) pending_q.push_back(rand_request(1));
        wait (hold_done);
        hold_results = 0;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 120)
                quiet_mode = 1;
            pending_q.push_back(rand_request($urandom_range(0, 9) != 0));
            while (pending_q.size() > 4)
                @(posedge clk);
        end
        stim_done = 1;
    end

    // Drive requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_valid <= 1'b0;
            operand       <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (operand_valid && operand_ready)
            begin
                fraction_q.push_back(reduce_fraction(operand));
                void'(pending_q.pop_front());
            end
            if (operand_valid && !operand_ready)
            begin
                // hold request
            end
            else if (send_gap > 0)
            begin
                send_gap      <= send_gap - 1;
                operand_valid <= 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 7) == 0)
            begin
                send_gap      <= $urandom_range(1, 10) - 1;
                operand_valid <= 1'b0;
            end
            else if (pending_q.size() > (operand_valid && operand_ready ? 0 : 0))
            begin
                operand_valid <= 1'b1;
                operand       <= pending_q[0];
            end
            else
                operand_valid <= 1'b0;
        end
    end

    // Accept and check results
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_gap     <= 0;
            hold_cycles  <= 0;
            hold_done    <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (fraction_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = fraction_q.pop_front();
                    if (result.result_numerator !== want.result_numerator)
                    begin
                        $display("%0t: numerator expected %0d actual %0d", $time,
                                 want.result_numerator, result.result_numerator);
                        fail_count++;
                    end
                    if (result.result_denominator !== want.result_denominator)
                    begin
                        $display("%0t: denominator expected %0d actual %0d", $time,
                                 want.result_denominator, result.result_denominator);
                        fail_count++;
                    end
                    if (result.error !== want.error)
                    begin
                        $display("%0t: error expected %0b actual %0b", $time,
                                 want.error, result.error);
                        fail_count++;
                    end
                end
            end
            // Hold off for a counted stretch once asked to
            if (hold_results && !hold_done)
            begin
                result_ready <= 1'b0;
                hold_cycles  <= hold_cycles + 1;
                if (hold_cycles >= HOLD_CYCLES - 1)
                    hold_done <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap     <= recv_gap - 1;
                result_ready <= 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 5) == 0)
            begin
                recv_gap     <= $urandom_range(1, 10) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Watchdog on accepted traffic
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((operand_valid && operand_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (hold_results)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Drain and report
    initial
    begin
        wait (stim_done && pending_q.size() == 0 && fraction_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
design/rau_pkg.sv
design/rational_arithmetic_unit.sv
dv/tb_top.sv
